/* hdl/fsbg_pkg.sv */
// ---------------------------------------------------------------------------
// Frame skip boost governor package
// Shared types, register indexes, field widths and reset values.
// ---------------------------------------------------------------------------
package fsbg_pkg;

    // Event kinds carried by op.
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BEGIN = 2'd1,
        OP_END   = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_TPF      = 3'd0,
        CFG_INTERVAL = 3'd1,
        CFG_BACKOFF  = 3'd2,
        CFG_RESUME   = 3'd3,
        CFG_LATE_UP  = 3'd4,
        CFG_LATE_DN  = 3'd5,
        CFG_SKIP_CAP = 3'd6
    } cfg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int TPF_W      = 24;
    localparam int IVL_W      = 32;
    localparam int PCT_W      = 7;
    localparam int TEMP_W     = 8;
    localparam int BUDGET_W   = 3;
    localparam int TIER_W     = 2;

    // Shift-and-add multiply of the late-percent check.
    localparam int MUL_W      = 8;
    localparam int MUL_STEPS  = 8;
    localparam logic [MUL_W-1:0] LATE_SCALE = 8'd100;

    localparam logic [TPF_W-1:0]    TPF_RST      = 24'd320000;
    localparam logic [IVL_W-1:0]    IVL_RST      = 32'd19200000;
    localparam logic [PCT_W-1:0]    BACKOFF_RST  = 7'd72;
    localparam logic [PCT_W-1:0]    RESUME_RST   = 7'd65;
    localparam logic [PCT_W-1:0]    LATE_UP_RST  = 7'd10;
    localparam logic [PCT_W-1:0]    LATE_DN_RST  = 7'd2;
    localparam logic [BUDGET_W-1:0] SKIP_CAP_RST = 3'd5;
    localparam logic [TEMP_W-1:0]   NO_TEMP      = 8'hFF;

    // Control from the sequencer to the serial time unit.
    typedef struct packed {
        logic load;
        logic shift;
        logic commit;
        op_t  op;
    } tp_ctl_t;

    // Flags the serial time unit leaves after a full pass.
    typedef struct packed {
        logic late;
        logic debt_gt;
        logic due;
    } tp_stat_t;

    typedef struct packed {
        logic load;
        logic step;
    } mul_ctl_t;

    function automatic logic [BUDGET_W-1:0] tier_budget(input logic [TIER_W-1:0] tier);
        logic [BUDGET_W-1:0] b;
        case (tier)
            2'd0:    b = 3'd0;
            2'd1:    b = 3'd1;
            2'd2:    b = 3'd3;
            default: b = 3'd5;
        endcase
        return b;
    endfunction

endpackage

/* hdl/fsbg_time_pass.sv */
// ---------------------------------------------------------------------------
// Frame skip boost governor serial time unit
// Holds debt, frame start and review time as rotating shift registers and
// works all time arithmetic one bit per cycle, least significant bit first.
// ---------------------------------------------------------------------------
module fsbg_time_pass #(
    parameter int TIME_BITS = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fsbg_pkg::tp_ctl_t            ctl,
    input  logic [TIME_BITS-1:0]         now,
    input  logic [fsbg_pkg::TPF_W-1:0]   tpf,
    input  logic [fsbg_pkg::IVL_W-1:0]   ivl,
    output fsbg_pkg::tp_stat_t           stat
);

    localparam int W = TIME_BITS;

    logic [W-1:0] now_sh_reg, tpf_sh_reg, ivl_sh_reg, cand_reg;
    logic [W-1:0] debt_reg, debt_next;
    logic [W-1:0] fstart_reg, fstart_next;
    logic [W-1:0] rat_reg, rat_next;
    logic bel_reg, bel_next;
    logic csum_reg, csum_next;
    logic bsub_reg, bsub_next;
    logic bdue_reg, bdue_next;
    logic crat_reg, crat_next;
    logic late_reg, late_next;
    logic dgt_reg, dgt_next;
    logic msb_reg, msb_next;

    logic n0, f0, d0, t0, r0, i0;
    logic el, sm, df, du, ca;
    logic is_start, is_begin, is_end;
    logic [W-1:0] tpf_ext;

    always_comb
    begin
        n0 = now_sh_reg[0];
        f0 = fstart_reg[0];
        d0 = debt_reg[0];
        t0 = tpf_sh_reg[0];
        r0 = rat_reg[0];
        i0 = ivl_sh_reg[0];

        is_start = (ctl.op == fsbg_pkg::OP_START);
        is_begin = (ctl.op == fsbg_pkg::OP_BEGIN);
        is_end   = (ctl.op == fsbg_pkg::OP_END);
        tpf_ext  = W'(tpf);

        // Elapsed time, now minus frame start.
        el = n0 ^ f0 ^ bel_reg;
        // Debt plus elapsed; the final carry means saturation.
        sm = d0 ^ el ^ csum_reg;
        // That sum minus the target; the final borrow means it fell below.
        df = sm ^ t0 ^ bsub_reg;
        // Now minus review time; its top bit decides whether a review is due.
        du = n0 ^ r0 ^ bdue_reg;
        // Next review time.
        ca = n0 ^ i0 ^ crat_reg;

        bel_next  = bel_reg;
        csum_next = csum_reg;
        bsub_next = bsub_reg;
        bdue_next = bdue_reg;
        crat_next = crat_reg;
        late_next = late_reg;
        dgt_next  = dgt_reg;
        msb_next  = msb_reg;
        debt_next   = debt_reg;
        fstart_next = fstart_reg;
        rat_next    = rat_reg;

        if (ctl.load)
        begin
            bel_next  = 1'b0;
            csum_next = 1'b0;
            bsub_next = 1'b0;
            bdue_next = 1'b0;
            crat_next = 1'b0;
            late_next = 1'b0;
            dgt_next  = 1'b0;
            msb_next  = 1'b0;
        end
        else if (ctl.shift)
        begin
            bel_next  = (~n0 & f0) | (~(n0 ^ f0) & bel_reg);
            csum_next = (d0 & el) | (csum_reg & (d0 ^ el));
            bsub_next = (~sm & t0) | (~(sm ^ t0) & bsub_reg);
            bdue_next = (~n0 & r0) | (~(n0 ^ r0) & bdue_reg);
            crat_next = (n0 & i0) | (crat_reg & (n0 ^ i0));
            // Least significant first: the highest differing bit decides.
            late_next = (el != t0) ? el : late_reg;
            dgt_next  = (d0 != t0) ? d0 : dgt_reg;
            msb_next  = du;
            debt_next   = {(is_end ? df : d0), debt_reg[W-1:1]};
            fstart_next = {((is_start || is_begin) ? n0 : f0), fstart_reg[W-1:1]};
            rat_next    = {r0, rat_reg[W-1:1]};
        end
        else if (ctl.commit)
        begin
            if (is_start)
            begin
                debt_next = '0;
            end
            else if (is_end)
            begin
                if (csum_reg)
                begin
                    debt_next = ~tpf_ext;
                end
                else if (bsub_reg)
                begin
                    debt_next = '0;
                end
            end
            if (is_start || (is_end && !msb_reg))
            begin
                rat_next = cand_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debt_reg   <= '0;
            fstart_reg <= '0;
            rat_reg    <= '0;
            bel_reg    <= 1'b0;
            csum_reg   <= 1'b0;
            bsub_reg   <= 1'b0;
            bdue_reg   <= 1'b0;
            crat_reg   <= 1'b0;
            late_reg   <= 1'b0;
            dgt_reg    <= 1'b0;
            msb_reg    <= 1'b0;
        end
        else
        begin
            debt_reg   <= debt_next;
            fstart_reg <= fstart_next;
            rat_reg    <= rat_next;
            bel_reg    <= bel_next;
            csum_reg   <= csum_next;
            bsub_reg   <= bsub_next;
            bdue_reg   <= bdue_next;
            crat_reg   <= crat_next;
            late_reg   <= late_next;
            dgt_reg    <= dgt_next;
            msb_reg    <= msb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            now_sh_reg <= now;
            tpf_sh_reg <= W'(tpf);
            ivl_sh_reg <= W'(ivl);
        end
        else if (ctl.shift)
        begin
            now_sh_reg <= {1'b0, now_sh_reg[W-1:1]};
            tpf_sh_reg <= {1'b0, tpf_sh_reg[W-1:1]};
            ivl_sh_reg <= {1'b0, ivl_sh_reg[W-1:1]};
            cand_reg   <= {ca, cand_reg[W-1:1]};
        end
    end

    assign stat.late    = late_reg;
    assign stat.debt_gt = dgt_reg;
    assign stat.due     = ~msb_reg;

endmodule

/* hdl/fsbg_pct_mul.sv */
// ---------------------------------------------------------------------------
// Frame skip boost governor late-percent unit
// Shift-and-add products that compare late frames against the percent
// limits without a divider, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module fsbg_pct_mul #(
    parameter int COUNT_BITS = 16
) (
    input  logic                         clk,
    input  fsbg_pkg::mul_ctl_t           ctl,
    input  logic [COUNT_BITS-1:0]        late,
    input  logic [COUNT_BITS-1:0]        frames,
    input  logic [fsbg_pkg::PCT_W-1:0]   up_pct,
    input  logic [fsbg_pkg::PCT_W-1:0]   down_pct,
    output logic                         up_hit,
    output logic                         down_hit
);

    localparam int PW = COUNT_BITS + fsbg_pkg::MUL_W;

    logic [fsbg_pkg::MUL_W-1:0] ma_reg, mb_reg, mc_reg;
    logic [PW-1:0] late_sh_reg, fc_sh_reg;
    logic [PW-1:0] acc_a_reg, acc_b_reg, acc_c_reg;

    // late*100 >= (up+1)*frames means the whole percent exceeds the upper
    // limit; late*100 < down*frames means it falls below the lower one.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            ma_reg      <= fsbg_pkg::LATE_SCALE;
            mb_reg      <= fsbg_pkg::MUL_W'(up_pct) + fsbg_pkg::MUL_W'(1);
            mc_reg      <= fsbg_pkg::MUL_W'(down_pct);
            late_sh_reg <= PW'(late);
            fc_sh_reg   <= PW'(frames);
            acc_a_reg   <= '0;
            acc_b_reg   <= '0;
            acc_c_reg   <= '0;
        end
        else if (ctl.step)
        begin
            if (ma_reg[0])
            begin
                acc_a_reg <= acc_a_reg + late_sh_reg;
            end
            if (mb_reg[0])
            begin
                acc_b_reg <= acc_b_reg + fc_sh_reg;
            end
            if (mc_reg[0])
            begin
                acc_c_reg <= acc_c_reg + fc_sh_reg;
            end
            ma_reg      <= {1'b0, ma_reg[fsbg_pkg::MUL_W-1:1]};
            mb_reg      <= {1'b0, mb_reg[fsbg_pkg::MUL_W-1:1]};
            mc_reg      <= {1'b0, mc_reg[fsbg_pkg::MUL_W-1:1]};
            late_sh_reg <= {late_sh_reg[PW-2:0], 1'b0};
            fc_sh_reg   <= {fc_sh_reg[PW-2:0], 1'b0};
        end
    end

    assign up_hit   = (acc_a_reg >= acc_b_reg);
    assign down_hit = (acc_a_reg < acc_c_reg);

endmodule

/* hdl/frame_skip_boost_governor_unit.sv */
// ---------------------------------------------------------------------------
// Frame skip boost governor
// Frame pacing governor with skip budget, debt tracking and boost control.
// ---------------------------------------------------------------------------
// Flow: an item runs a bit-serial time pass over the debt, frame and review
// times and a commit; a frame end that is due for review adds a thermal check
// and a shift-and-add late-percent check before the result is emitted.
// A new item is taken only once the previous result has been emitted.
// Reset: all governor state clears, last temperature reads as none, the
// configuration registers take their default values; no clearing pass.
module frame_skip_boost_governor_unit #(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fsbg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fsbg_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        op,
    input  logic [TIME_BITS-1:0]              now,
    input  logic [fsbg_pkg::TIER_W-1:0]       tier,
    input  logic                              temp_valid,
    input  logic signed [7:0]                 temp_c,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              skip_frame,
    output logic                              boost_on,
    output logic                              thermal_hold,
    output logic [fsbg_pkg::BUDGET_W-1:0]     skip_budget,
    output logic                              review_done
);

    localparam int CNT_W = $clog2(TIME_BITS);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PASS  = 7'b0000010,
        S_FIN   = 7'b0000100,
        S_THERM = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_CMP   = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Configuration.
    logic [fsbg_pkg::TPF_W-1:0]    tpf_reg;
    logic [fsbg_pkg::IVL_W-1:0]    ivl_reg;
    logic [fsbg_pkg::PCT_W-1:0]    backoff_reg, resume_reg, late_up_reg, late_dn_reg;
    logic [fsbg_pkg::BUDGET_W-1:0] cap_reg;

    // Governor state.
    logic boosted_reg, boosted_next;
    logic hold_reg, hold_next;
    logic skip_reg, skip_next;
    logic reviewed_reg, reviewed_next;
    logic [fsbg_pkg::BUDGET_W-1:0] budget_reg, budget_next;
    logic [fsbg_pkg::BUDGET_W-1:0] run_reg, run_next;
    logic [COUNT_BITS-1:0] late_cnt_reg, late_cnt_next;
    logic [COUNT_BITS-1:0] frame_cnt_reg, frame_cnt_next;
    logic [fsbg_pkg::TEMP_W-1:0] last_temp_reg, last_temp_next;
    logic out_valid_reg, out_valid_next;

    // Captured item.
    fsbg_pkg::op_t op_reg;
    logic [fsbg_pkg::TIER_W-1:0] tier_reg;
    logic tv_reg;
    logic [fsbg_pkg::TEMP_W-1:0] temp_reg;

    logic skip_out_reg, boost_out_reg, hold_out_reg, review_out_reg;
    logic [fsbg_pkg::BUDGET_W-1:0] budget_out_reg;

    fsbg_pkg::tp_ctl_t  tp_ctl;
    fsbg_pkg::tp_stat_t tp_stat;
    fsbg_pkg::mul_ctl_t mul_ctl;
    logic up_hit, down_hit;
    logic accept, emit;
    logic [fsbg_pkg::TEMP_W-1:0] cur_temp;
    logic [fsbg_pkg::BUDGET_W-1:0] run_inc;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;

    fsbg_time_pass #(
        .TIME_BITS (TIME_BITS)
    ) u_time (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (tp_ctl),
        .now   (now),
        .tpf   (tpf_reg),
        .ivl   (ivl_reg),
        .stat  (tp_stat)
    );

    fsbg_pct_mul #(
        .COUNT_BITS (COUNT_BITS)
    ) u_pct (
        .clk      (clk),
        .ctl      (mul_ctl),
        .late     (late_cnt_reg),
        .frames   (frame_cnt_reg),
        .up_pct   (late_up_reg),
        .down_pct (late_dn_reg),
        .up_hit   (up_hit),
        .down_hit (down_hit)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        boosted_next   = boosted_reg;
        hold_next      = hold_reg;
        skip_next      = skip_reg;
        reviewed_next  = reviewed_reg;
        budget_next    = budget_reg;
        run_next       = run_reg;
        late_cnt_next  = late_cnt_reg;
        frame_cnt_next = frame_cnt_reg;
        last_temp_next = last_temp_reg;
        emit           = 1'b0;
        run_inc        = 3'd0;

        tp_ctl.load   = 1'b0;
        tp_ctl.shift  = 1'b0;
        tp_ctl.commit = 1'b0;
        tp_ctl.op     = op_reg;
        mul_ctl.load  = 1'b0;
        mul_ctl.step  = 1'b0;

        cur_temp = tv_reg ? temp_reg : last_temp_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    tp_ctl.load   = 1'b1;
                    cnt_next      = '0;
                    reviewed_next = 1'b0;
                    state_next    = S_PASS;
                end
            end
            S_PASS:
            begin
                tp_ctl.shift = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TIME_BITS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                tp_ctl.commit = 1'b1;
                state_next    = S_EMIT;
                case (op_reg)
                    fsbg_pkg::OP_START:
                    begin
                        run_next       = '0;
                        skip_next      = 1'b0;
                        late_cnt_next  = '0;
                        frame_cnt_next = '0;
                        budget_next    = fsbg_pkg::tier_budget(tier_reg);
                        boosted_next   = tier_reg[1] && !hold_reg;
                    end
                    fsbg_pkg::OP_BEGIN:
                    begin
                        run_inc = run_reg + 3'd1;
                        if (tp_stat.debt_gt && (run_reg < budget_reg))
                        begin
                            run_next  = run_inc;
                            skip_next = 1'b1;
                        end
                        else
                        begin
                            run_next  = '0;
                            skip_next = 1'b0;
                        end
                    end
                    fsbg_pkg::OP_END:
                    begin
                        // The counters freeze once the frame count saturates.
                        if (frame_cnt_reg != '1)
                        begin
                            frame_cnt_next = frame_cnt_reg + COUNT_BITS'(1);
                            if (tp_stat.late)
                            begin
                                late_cnt_next = late_cnt_reg + COUNT_BITS'(1);
                            end
                        end
                        if (tp_stat.due)
                        begin
                            reviewed_next = 1'b1;
                            state_next    = S_THERM;
                        end
                    end
                    default:
                    begin
                        boosted_next = 1'b0;
                    end
                endcase
            end
            S_THERM:
            begin
                last_temp_next = cur_temp;
                // A negative reading, including the no-reading mark, skips
                // the thermal rule.
                if (!cur_temp[fsbg_pkg::TEMP_W-1])
                begin
                    if (!hold_reg && (cur_temp[fsbg_pkg::PCT_W-1:0] >= backoff_reg))
                    begin
                        hold_next    = 1'b1;
                        boosted_next = 1'b0;
                        if (budget_reg < cap_reg)
                        begin
                            budget_next = budget_reg + 3'd1;
                        end
                    end
                    else if (hold_reg && (cur_temp[fsbg_pkg::PCT_W-1:0] <= resume_reg))
                    begin
                        hold_next = 1'b0;
                    end
                end
                mul_ctl.load = 1'b1;
                cnt_next     = '0;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                mul_ctl.step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(fsbg_pkg::MUL_STEPS - 1))
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (frame_cnt_reg != '0)
                begin
                    if (!boosted_reg && up_hit)
                    begin
                        boosted_next = !hold_reg;
                    end
                    else if (boosted_reg && down_hit)
                    begin
                        boosted_next = 1'b0;
                    end
                end
                late_cnt_next  = '0;
                frame_cnt_next = '0;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            boosted_reg   <= 1'b0;
            hold_reg      <= 1'b0;
            skip_reg      <= 1'b0;
            reviewed_reg  <= 1'b0;
            budget_reg    <= '0;
            run_reg       <= '0;
            late_cnt_reg  <= '0;
            frame_cnt_reg <= '0;
            last_temp_reg <= fsbg_pkg::NO_TEMP;
            out_valid_reg <= 1'b0;
            tpf_reg       <= fsbg_pkg::TPF_RST;
            ivl_reg       <= fsbg_pkg::IVL_RST;
            backoff_reg   <= fsbg_pkg::BACKOFF_RST;
            resume_reg    <= fsbg_pkg::RESUME_RST;
            late_up_reg   <= fsbg_pkg::LATE_UP_RST;
            late_dn_reg   <= fsbg_pkg::LATE_DN_RST;
            cap_reg       <= fsbg_pkg::SKIP_CAP_RST;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            boosted_reg   <= boosted_next;
            hold_reg      <= hold_next;
            skip_reg      <= skip_next;
            reviewed_reg  <= reviewed_next;
            budget_reg    <= budget_next;
            run_reg       <= run_next;
            late_cnt_reg  <= late_cnt_next;
            frame_cnt_reg <= frame_cnt_next;
            last_temp_reg <= last_temp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fsbg_pkg::CFG_TPF:      tpf_reg     <= cfg_data[fsbg_pkg::TPF_W-1:0];
                    fsbg_pkg::CFG_INTERVAL: ivl_reg     <= cfg_data[fsbg_pkg::IVL_W-1:0];
                    fsbg_pkg::CFG_BACKOFF:  backoff_reg <= cfg_data[fsbg_pkg::PCT_W-1:0];
                    fsbg_pkg::CFG_RESUME:   resume_reg  <= cfg_data[fsbg_pkg::PCT_W-1:0];
                    fsbg_pkg::CFG_LATE_UP:  late_up_reg <= cfg_data[fsbg_pkg::PCT_W-1:0];
                    fsbg_pkg::CFG_LATE_DN:  late_dn_reg <= cfg_data[fsbg_pkg::PCT_W-1:0];
                    fsbg_pkg::CFG_SKIP_CAP: cap_reg     <= cfg_data[fsbg_pkg::BUDGET_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= fsbg_pkg::op_t'(op);
            tier_reg <= tier;
            tv_reg   <= temp_valid;
            temp_reg <= temp_c;
        end
        if (emit)
        begin
            skip_out_reg   <= skip_reg;
            boost_out_reg  <= boosted_reg;
            hold_out_reg   <= hold_reg;
            budget_out_reg <= budget_reg;
            review_out_reg <= reviewed_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign skip_frame   = skip_out_reg;
    assign boost_on     = boost_out_reg;
    assign thermal_hold = hold_out_reg;
    assign skip_budget  = budget_out_reg;
    assign review_done  = review_out_reg;

endmodule
